// ===== hw/rtl/sfls_pkg.sv =====
// ----------------------------------------------------------------------------
// sfls_pkg
// Shared types and constants of the scanline fill/literal segmenter.
// ----------------------------------------------------------------------------
package sfls_pkg;

    localparam int MAX_LINE_WIDTH = 1024;
    localparam int COL_W          = $clog2(MAX_LINE_WIDTH);
    localparam int LEN_W          = COL_W + 1;
    localparam int COLOR_W        = 16;
    localparam int ROW_W          = 10;
    localparam int THR_W          = 8;
    localparam int NUM_CAND       = 5;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = QPTR_W + 1;

    localparam int IN_DATA_BITS   = COLOR_W + ROW_W;
    localparam int IN_DATA_W      = ((IN_DATA_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS  = COL_W + LEN_W + COLOR_W + ROW_W;
    localparam int OUT_DATA_W     = ((OUT_DATA_BITS + 7) / 8) * 8;
    localparam int OUT_USER_W     = 2;

    localparam logic [THR_W-1:0] FILL_RUN_RESET = THR_W'(8);
    localparam logic [COL_W-1:0] LAST_COL       = COL_W'(MAX_LINE_WIDTH - 1);

    localparam logic KIND_LITERAL = 1'b0;
    localparam logic KIND_FILL    = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [COL_W-1:0]   start;
        logic [LEN_W-1:0]   len;
        logic [COLOR_W-1:0] color;
    } sfls_seg_t;

    typedef struct packed {
        logic [NUM_CAND-1:0]          mask;
        logic                         eol;
        logic [ROW_W-1:0]             row;
        sfls_seg_t [NUM_CAND-1:0]     seg;
    } sfls_rec_t;

endpackage

// ===== hw/rtl/scanline_fill_literal_segmenter.sv =====
// ----------------------------------------------------------------------------
// scanline_fill_literal_segmenter
// Splits RGB565 scanlines into fill and literal segments.
// ----------------------------------------------------------------------------
// One pixel is taken per clock while each pixel closes at most one segment
// and the output is not held off; the output port emits one segment per
// clock while m_tready is high, so a pixel that closes k segments (up to
// three) leaves as k transfers. The front end classifies each pixel
// combinationally and pushes a record into a four-entry queue; the back
// end walks it one segment a cycle, unless the output stalls, into the
// output register. The user must write min_fill_run on the cfg channel
// only while the block is idle; the block itself does not enforce this.
module scanline_fill_literal_segmenter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sfls_pkg::THR_W-1:0]        cfg_data,       // min_fill_run
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sfls_pkg::IN_DATA_W-1:0]    s_tdata,        // pixel_color, line_row
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sfls_pkg::OUT_DATA_W-1:0]   m_tdata,        // start_column,
                                                              // segment_length,
                                                              // fill_color, segment_row
    output logic                              m_tlast,
    output logic [sfls_pkg::OUT_USER_W-1:0]   m_tuser         // segment_kind, last_of_item
);
    import sfls_pkg::*;

    logic      push_valid, q_full, q_empty, pop;
    sfls_rec_t push_rec, head_rec;

    sfls_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_rec   (push_rec)
    );

    sfls_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_rec   (push_rec),
        .q_full     (q_full),
        .pop        (pop),
        .head_rec   (head_rec),
        .q_empty    (q_empty)
    );

    sfls_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_rec (head_rec),
        .q_empty  (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== hw/rtl/sfls_front.sv =====
// ----------------------------------------------------------------------------
// sfls_front
// Accepts pixels, tracks runs and classifies the segments each pixel closes.
// ----------------------------------------------------------------------------
module sfls_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sfls_pkg::THR_W-1:0]        cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sfls_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                              s_tlast,
    input  logic                              q_full,
    output logic                              push_valid,
    output sfls_pkg::sfls_rec_t               push_rec
);
    import sfls_pkg::*;

    logic [THR_W-1:0]   min_fill_run_reg;
    logic [COL_W-1:0]   column_count_reg, column_count_next;
    logic [COL_W-1:0]   literal_start_reg, literal_start_next;
    logic [COL_W-1:0]   run_start_reg, run_start_next;
    logic [COLOR_W-1:0] run_color_reg, run_color_next;
    logic               line_open_reg, line_open_next;

    logic [COLOR_W-1:0] color;
    logic [ROW_W-1:0]   row;
    logic               accept;
    logic [COL_W-1:0]   col;
    logic [LEN_W-1:0]   col_x, col_p1, thr;
    logic [COL_W-1:0]   lit_s0, run_s0, lit_s1, run_s1;
    logic [COLOR_W-1:0] run_c0, run_c1;
    logic               change, eol_eff;
    logic [LEN_W-1:0]   len_a, len_b, lit_s2;
    logic               fire_a, fire_b, lit_a, lit_b, lit_c;

    assign color     = s_tdata[COLOR_W-1:0];
    assign row       = s_tdata[COLOR_W +: ROW_W];
    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;

    always_comb begin
        col    = line_open_reg ? ((column_count_reg >= LAST_COL) ? LAST_COL : column_count_reg)
                               : '0;
        col_x  = {1'b0, col};
        col_p1 = col_x + LEN_W'(1);
        thr    = LEN_W'(min_fill_run_reg);
        lit_s0 = line_open_reg ? literal_start_reg : '0;
        run_s0 = line_open_reg ? run_start_reg : '0;
        run_c0 = line_open_reg ? run_color_reg : color;
        change = line_open_reg && (color != run_color_reg);

        len_a  = col_x - {1'b0, run_s0};
        fire_a = change && (len_a >= thr);
        lit_a  = fire_a && (lit_s0 < run_s0);
        lit_s1 = fire_a ? col : lit_s0;
        run_s1 = change ? col : run_s0;
        run_c1 = change ? color : run_c0;

        eol_eff = s_tlast || (col == LAST_COL);
        len_b   = col_p1 - {1'b0, run_s1};
        fire_b  = eol_eff && (len_b >= thr);
        lit_b   = fire_b && (lit_s1 < run_s1);
        lit_s2  = fire_b ? col_p1 : {1'b0, lit_s1};
        lit_c   = eol_eff && (lit_s2 < col_p1);

        push_rec.mask = {lit_c, fire_b, lit_b, fire_a, lit_a};
        push_rec.eol  = eol_eff;
        push_rec.row  = row;
        push_rec.seg[0] = '{KIND_LITERAL, lit_s0,
                            {1'b0, run_s0} - {1'b0, lit_s0}, '0};
        push_rec.seg[1] = '{KIND_FILL, run_s0, len_a, run_c0};
        push_rec.seg[2] = '{KIND_LITERAL, lit_s1,
                            {1'b0, run_s1} - {1'b0, lit_s1}, '0};
        push_rec.seg[3] = '{KIND_FILL, run_s1, len_b, run_c1};
        push_rec.seg[4] = '{KIND_LITERAL, lit_s2[COL_W-1:0], col_p1 - lit_s2, '0};

        push_valid = accept && (push_rec.mask != '0);

        column_count_next  = column_count_reg;
        literal_start_next = literal_start_reg;
        run_start_next     = run_start_reg;
        run_color_next     = run_color_reg;
        line_open_next     = line_open_reg;
        if (accept) begin
            literal_start_next = lit_s1;
            run_start_next     = run_s1;
            run_color_next     = run_c1;
            if (eol_eff) begin
                line_open_next    = 1'b0;
                column_count_next = '0;
            end else begin
                line_open_next    = 1'b1;
                column_count_next = col_p1[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_fill_run_reg  <= FILL_RUN_RESET;
            column_count_reg  <= '0;
            literal_start_reg <= '0;
            run_start_reg     <= '0;
            run_color_reg     <= '0;
            line_open_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                min_fill_run_reg <= cfg_data;
            end
            column_count_reg  <= column_count_next;
            literal_start_reg <= literal_start_next;
            run_start_reg     <= run_start_next;
            run_color_reg     <= run_color_next;
            line_open_reg     <= line_open_next;
        end
    end

endmodule

// ===== hw/rtl/sfls_queue.sv =====
// ----------------------------------------------------------------------------
// sfls_queue
// Short queue of classified pixel records between front and back.
// ----------------------------------------------------------------------------
module sfls_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    input  sfls_pkg::sfls_rec_t  push_rec,
    output logic                 q_full,
    input  logic                 pop,
    output sfls_pkg::sfls_rec_t  head_rec,
    output logic                 q_empty
);
    import sfls_pkg::*;

    sfls_rec_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push, do_pop;

    assign q_full   = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_empty  = (count_reg == '0);
    assign head_rec = entry_reg[rd_ptr_reg];
    assign do_push  = push_valid && !q_full;
    assign do_pop   = pop && !q_empty;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== hw/rtl/sfls_back.sv =====
// ----------------------------------------------------------------------------
// sfls_back
// Walks the segments of each queued record and drives the output register.
// ----------------------------------------------------------------------------
module sfls_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  sfls_pkg::sfls_rec_t               head_rec,
    input  logic                              q_empty,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sfls_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tlast,
    output logic [sfls_pkg::OUT_USER_W-1:0]   m_tuser
);
    import sfls_pkg::*;

    logic [NUM_CAND-1:0] done_reg, done_next;
    logic [NUM_CAND-1:0] rem, pick;
    logic                last_pick, load;
    sfls_seg_t           sel;

    logic                out_valid_reg;
    sfls_seg_t           out_seg_reg;
    logic [ROW_W-1:0]    out_row_reg;
    logic                out_line_reg;
    logic                out_item_reg;

    always_comb begin
        rem       = head_rec.mask & ~done_reg;
        pick      = rem & (~rem + NUM_CAND'(1));
        last_pick = ((rem & ~pick) == '0);
        load      = !q_empty && (!out_valid_reg || m_tready);
        pop       = load && last_pick;
        sel       = '0;
        for (int i = 0; i < NUM_CAND; i++) begin
            if (pick[i]) begin
                sel = head_rec.seg[i];
            end
        end
        done_next = done_reg;
        if (load) begin
            done_next = last_pick ? '0 : (done_reg | pick);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_seg_reg  <= sel;
            out_row_reg  <= head_rec.row;
            out_item_reg <= last_pick;
            out_line_reg <= last_pick && head_rec.eol;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            done_reg      <= '0;
        end else begin
            done_reg <= done_next;
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_line_reg;
    assign m_tuser  = {out_item_reg, out_seg_reg.kind};
    assign m_tdata  = OUT_DATA_W'({out_row_reg, out_seg_reg.color,
                                   out_seg_reg.len, out_seg_reg.start});

    a_line_ends_item: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_line_reg |-> out_item_reg)
        else $error("last segment of line not last of its pixel");

    a_literal_no_color: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_seg_reg.kind == KIND_LITERAL) |-> (out_seg_reg.color == '0))
        else $error("literal segment carries a color");

    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_seg_reg.len != '0))
        else $error("empty segment emitted");

    a_inside_line: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |->
            (({1'b0, out_seg_reg.start} + {1'b0, out_seg_reg.len}) <= (LEN_W + 1)'(MAX_LINE_WIDTH)))
        else $error("segment runs past the line end");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the scanline fill/literal segmenter.
// ----------------------------------------------------------------------------
// Pixels go in as stream transactions and segments come back one per
// transaction. A scoreboard predicts the segments of every accepted pixel
// and checks each segment against the oldest one expected. The run starts
// with short directed lines, goes through random lines under several
// thresholds and idling patterns, and holds the output off once to back the
// block up.
// ----------------------------------------------------------------------------
module tb_top;

    import sfls_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int HOLD_CYCLES    = 300;

    localparam int LEN_LO   = COL_W;
    localparam int COLOR_LO = LEN_LO + LEN_W;
    localparam int ROW_LO   = COLOR_LO + COLOR_W;

    typedef struct packed {
        logic               kind;
        logic [COL_W-1:0]   start;
        logic [LEN_W-1:0]   len;
        logic [COLOR_W-1:0] color;
        logic [ROW_W-1:0]   row;
        logic               line_end;
        logic               pixel_end;
    } segment_t;

    class segment_scoreboard;
        logic [THR_W-1:0]   min_fill;
        logic [COL_W-1:0]   next_col;
        logic [LEN_W-1:0]   lit_start;
        logic [COL_W-1:0]   run_first;
        logic [COLOR_W-1:0] run_color;
        logic               in_line;
        logic [ROW_W-1:0]   cur_row;
        segment_t           expected_segs[$];
        segment_t           closed_segs[$];
        int                 errors;

        function new();
            min_fill  = FILL_RUN_RESET;
            next_col  = '0;
            lit_start = '0;
            run_first = '0;
            run_color = '0;
            in_line   = 1'b0;
            cur_row   = '0;
            errors    = 0;
        endfunction

        function int pending();
            return expected_segs.size();
        endfunction

        function void add_segment(logic kind, logic [COL_W-1:0] start,
                                  logic [LEN_W-1:0] len, logic [COLOR_W-1:0] color);
            segment_t s;
            s.kind      = kind;
            s.start     = start;
            s.len       = len;
            s.color     = (kind == KIND_FILL) ? color : '0;
            s.row       = cur_row;
            s.line_end  = 1'b0;
            s.pixel_end = 1'b0;
            closed_segs.push_back(s);
        endfunction

        // close the current run, which ends just before end_col
        function void close_run(logic [LEN_W-1:0] end_col);
            logic [LEN_W-1:0] run_len;
            run_len = end_col - {1'b0, run_first};
            if (run_len >= LEN_W'(min_fill)) begin
                if (lit_start < {1'b0, run_first})
                    add_segment(KIND_LITERAL, lit_start[COL_W-1:0],
                                {1'b0, run_first} - lit_start, '0);
                add_segment(KIND_FILL, run_first, run_len, run_color);
                lit_start = end_col;
            end
        endfunction

        function void note_pixel(logic [COLOR_W-1:0] color, logic [ROW_W-1:0] row,
                                 logic eol_in);
            logic [COL_W-1:0] col;
            logic [LEN_W-1:0] col_end;
            logic             eol;
            closed_segs.delete();
            cur_row = row;
            eol     = eol_in;
            if (!in_line) begin
                col       = '0;
                lit_start = '0;
                run_first = '0;
                run_color = color;
            end else begin
                col = next_col;
                if (color != run_color) begin
                    close_run({1'b0, col});
                    run_first = col;
                    run_color = color;
                end
            end
            if (col == LAST_COL)
                eol = 1'b1;
            col_end = {1'b0, col} + LEN_W'(1);
            if (eol) begin
                close_run(col_end);
                if (lit_start < col_end)
                    add_segment(KIND_LITERAL, lit_start[COL_W-1:0], col_end - lit_start, '0);
                if (closed_segs.size() > 0)
                    closed_segs[closed_segs.size()-1].line_end = 1'b1;
                in_line  = 1'b0;
                next_col = '0;
            end else begin
                in_line  = 1'b1;
                next_col = col + COL_W'(1);
            end
            if (closed_segs.size() > 0)
                closed_segs[closed_segs.size()-1].pixel_end = 1'b1;
            foreach (closed_segs[i])
                expected_segs.push_back(closed_segs[i]);
        endfunction

        function void check_segment(segment_t got);
            segment_t want;
            if (expected_segs.size() == 0) begin
                errors++;
                $display("%0t: unexpected segment kind=%0d start=%0d len=%0d color=%h row=%0d",
                         $time, got.kind, got.start, got.len, got.color, got.row);
                return;
            end
            want = expected_segs.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0t: segment mismatch", $time);
                $display("  expected kind=%0d start=%0d len=%0d color=%h row=%0d last=%0d item=%0d",
                         want.kind, want.start, want.len, want.color, want.row,
                         want.line_end, want.pixel_end);
                $display("  actual   kind=%0d start=%0d len=%0d color=%h row=%0d last=%0d item=%0d",
                         got.kind, got.start, got.len, got.color, got.row,
                         got.line_end, got.pixel_end);
            end
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [THR_W-1:0]      cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;   // pixel_color, line_row
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;          // start_column, segment_length,
                                             // fill_color, segment_row
    logic                  m_tlast;
    logic [OUT_USER_W-1:0] m_tuser;          // segment_kind, last_of_item

    segment_scoreboard sb = new();

    int s_idle_pct  = 0;
    int m_stall_pct = 0;
    int pixels_sent = 0;
    int hold_left   = 0;
    bit hold_go     = 1'b0;
    int idle_count  = 0;

    scanline_fill_literal_segmenter DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        segment_t got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.kind      = m_tuser[0];
                got.pixel_end = m_tuser[1];
                got.line_end  = m_tlast;
                got.start     = m_tdata[LEN_LO-1:0];
                got.len       = m_tdata[COLOR_LO-1:LEN_LO];
                got.color     = m_tdata[ROW_LO-1:COLOR_LO];
                got.row       = m_tdata[ROW_LO+ROW_W-1:ROW_LO];
                sb.check_segment(got);
            end
            if (hold_go) begin
                hold_go   = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= m_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_count <= 0;
            else
                idle_count <= idle_count + 1;
            if (idle_count >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d segments outstanding", $time, sb.pending());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic write_threshold(logic [THR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        sb.min_fill  = value;
    endtask

    task automatic send_pixel(logic [COLOR_W-1:0] color, logic [ROW_W-1:0] row, logic eol);
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'({row, color});
        s_tlast  <= eol;
        do @(posedge aclk); while (!s_tready);
        sb.note_pixel(color, row, eol);
        pixels_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [COLOR_W-1:0] pick_color(logic [COLOR_W-1:0] p0,
                                                       logic [COLOR_W-1:0] p1);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return p0;
            4:       return p1;
            default: return COLOR_W'($urandom);
        endcase
    endfunction

    task automatic send_random_line(int max_len, int max_run);
        int               left;
        int               run_len;
        logic [COLOR_W-1:0] c;
        logic [COLOR_W-1:0] p0;
        logic [COLOR_W-1:0] p1;
        logic [ROW_W-1:0] row;
        logic             no_eol;
        left   = $urandom_range(1, max_len);
        p0     = COLOR_W'($urandom);
        p1     = COLOR_W'($urandom);
        row    = ROW_W'($urandom);
        no_eol = ($urandom_range(0, 9) == 0);
        while (left > 0) begin
            run_len = $urandom_range(1, max_run);
            if (run_len > left)
                run_len = left;
            c = pick_color(p0, p1);
            repeat (run_len) begin
                send_pixel(c, ($urandom_range(0, 19) == 0) ? ROW_W'($urandom) : row,
                           (left == 1) && !no_eol);
                left--;
            end
        end
    endtask

    task automatic run_phase(int s_pct, int m_pct, logic [THR_W-1:0] thr, int n_items,
                             int max_len, int max_run, bit hold);
        int target;
        s_idle_pct  = s_pct;
        m_stall_pct = m_pct;
        write_threshold(thr);
        if (hold)
            hold_go = 1'b1;
        target = pixels_sent + n_items;
        while (pixels_sent < target)
            send_random_line(max_len, max_run);
        send_pixel(COLOR_W'($urandom), ROW_W'($urandom), 1'b1);
        drain();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset threshold: long run becomes a fill, short tail a literal
        repeat (8) send_pixel(16'hFFFF, 10'd0, 1'b0);
        send_pixel(16'h0000, 10'd1023, 1'b0);
        send_pixel(16'h1234, 10'd1023, 1'b0);
        send_pixel(16'h1234, 10'd1023, 1'b1);
        drain();

        // threshold one: every run fills, two segments on the last pixel
        write_threshold(8'd1);
        send_pixel(16'h0001, 10'd5, 1'b0);
        send_pixel(16'h0001, 10'd6, 1'b0);
        send_pixel(16'h8000, 10'd7, 1'b1);
        drain();

        // threshold zero: single-pixel lines back to back, then a two-pixel line
        write_threshold(8'd0);
        send_pixel(16'hAAAA, 10'd512, 1'b1);
        send_pixel(16'h5555, 10'd513, 1'b1);
        send_pixel(16'h5555, 10'd514, 1'b0);
        send_pixel(16'hAAAA, 10'd514, 1'b1);
        drain();

        // top threshold: literal only, row changes inside the line
        write_threshold(8'd255);
        send_pixel(16'h0F0F, 10'd100, 1'b0);
        send_pixel(16'h0F0F, 10'd200, 1'b0);
        send_pixel(16'hF0F0, 10'd300, 1'b0);
        send_pixel(16'hF0F0, 10'd400, 1'b1);
        drain();

        run_phase(0,  0,  8'($urandom_range(2, 10)), 25, 30, 12, 1'b0);
        run_phase(78, 0,  8'd0,                      20, 20, 4,  1'b0);
        run_phase(0,  78, 8'd1,                      20, 20, 4,  1'b0);
        run_phase(20, 20, 8'($urandom_range(3, 6)),  20, 30, 10, 1'b0);
        run_phase(0,  0,  8'd2,                      20, 12, 4,  1'b1);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
